// File: rtl/avr_pkg.sv
package avr_pkg;

  localparam int VEC_WIDTH    = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int AXIS_WIDTH   = 16;
  localparam int TOL_WIDTH    = 14;
  localparam int CORDIC_STEPS = 30;
  localparam int CORD_W       = 34;
  localparam int Q_W          = 34;
  localparam int Q_FRAC       = 30;
  localparam int SPLIT        = 17;
  localparam int T_W          = VEC_WIDTH + 6;
  localparam int U_W          = VEC_WIDTH + 12;
  localparam int DEV_W        = 35;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(16);
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [CORD_W-1:0] HALF_PI_Q30 = CORD_W'(1686629713);
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = CORD_W'(32'h26DD3B6A);
  localparam logic signed [DEV_W-1:0]  ONE_Q28 = DEV_W'(268435456);

  localparam logic signed [CORD_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6, 34'h003FEAB76,
    34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55, 34'h0003FFFEA, 34'h0001FFFFD,
    34'h0000FFFFF, 34'h00007FFFF, 34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF,
    34'h000007FFF, 34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
    34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F, 34'h00000003F,
    34'h00000001F, 34'h00000000F, 34'h000000008, 34'h000000004, 34'h000000002
  };

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
    logic signed [AXIS_WIDTH-1:0] axis_x;
    logic signed [AXIS_WIDTH-1:0] axis_y;
    logic signed [AXIS_WIDTH-1:0] axis_z;
    logic [ANGLE_WIDTH-1:0]       angle;
  } in_data_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        axis_not_unit;
    logic                        saturated;
  } out_data_t;

endpackage

// File: rtl/avr_cordic.sv
module avr_cordic import avr_pkg::*; (
  input  logic                     clk,
  input  logic [ANGLE_WIDTH-1:0]   angle,
  output logic signed [CORD_W-1:0] cos_half,
  output logic signed [CORD_W-1:0] sin_half
);

  logic [ANGLE_WIDTH+31:0]   theta_prod;
  logic signed [CORD_W-1:0]  z0_r;
  logic signed [CORD_W-1:0]  x_r [CORDIC_STEPS];
  logic signed [CORD_W-1:0]  y_r [CORDIC_STEPS];
  logic signed [CORD_W-1:0]  z_r [CORDIC_STEPS];

  assign theta_prod = (ANGLE_WIDTH+32)'(angle) * (ANGLE_WIDTH+32)'(PI_Q30);

  always_ff @(posedge clk) begin
    z0_r <= $signed({2'b00, theta_prod[ANGLE_WIDTH+31:ANGLE_WIDTH]}) - HALF_PI_Q30;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORD_W-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = z0_r;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!zi[CORD_W-1]) begin
        x_r[i] <= xi - (yi >>> i);
        y_r[i] <= yi + (xi >>> i);
        z_r[i] <= zi - ATAN_TAB[i];
      end else begin
        x_r[i] <= xi + (yi >>> i);
        y_r[i] <= yi - (xi >>> i);
        z_r[i] <= zi + ATAN_TAB[i];
      end
    end
  end

  assign cos_half = -y_r[CORDIC_STEPS-1];
  assign sin_half = x_r[CORDIC_STEPS-1];

endmodule

// File: rtl/avr_qmul.sv
module avr_qmul import avr_pkg::*; #(
  parameter int B_W = VEC_WIDTH
) (
  input  logic                          clk,
  input  logic signed [Q_W-1:0]         a,
  input  logic signed [B_W-1:0]         b,
  output logic signed [Q_W+B_W-31:0]    p
);

  logic signed [Q_W-SPLIT-1:0]   a_hi;
  logic signed [SPLIT:0]         a_lo;
  logic signed [Q_W-SPLIT+B_W-1:0] hi_r;
  logic signed [SPLIT+B_W:0]     lo_r;
  logic signed [Q_W+B_W-1:0]     full;

  assign a_hi = a[Q_W-1:SPLIT];
  assign a_lo = $signed({1'b0, a[SPLIT-1:0]});

  // two partial products, then exact floor of the full product
  always_ff @(posedge clk) begin
    hi_r <= a_hi * b;
    lo_r <= a_lo * b;
  end

  assign full = ((Q_W+B_W)'(hi_r) <<< SPLIT) + (Q_W+B_W)'(lo_r);

  always_ff @(posedge clk) begin
    p <= full[Q_W+B_W-1:Q_FRAC];
  end

endmodule

// File: rtl/axis_angle_vector_rotation.sv
// Rotates a Q16.16 vector about a Q2.14 axis by an angle given as a fraction
// of a full turn, using a 30-stage pipelined CORDIC for the half-angle sine
// and cosine and two pipelined Hamilton products. One transaction is taken
// every cycle (busy stays low) and its result appears on out_data with
// out_valid high for one cycle, after the CORDIC pipeline, the quaternion
// registers, both Hamilton products and the output register. The receiver
// cannot stall the block. The result also flags an axis whose squared length
// lies outside one plus or minus unit_tolerance, and any clipped component.
// Write unit_tolerance only while no transaction is in flight.
module axis_angle_vector_rotation import avr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_data_t             in_data,
  output logic                 out_valid,
  output out_data_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TOL_WIDTH-1:0] cfg_data
);

  localparam int CL  = CORDIC_STEPS + 1;
  localparam int LAT = CL + 8;
  localparam int TP_W = Q_W + VEC_WIDTH - 30;
  localparam int UP_W = Q_W + T_W - 30;

  logic [TOL_WIDTH-1:0] tol_r;
  logic [LAT-1:0]       vld_r;
  logic                 accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) tol_r <= cfg_data;
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // axis length check
  logic signed [DEV_W-1:0] ax_w, ay_w, az_w;
  logic signed [DEV_W-1:0] len2, dev, dev_abs;
  assign ax_w = DEV_W'(in_data.axis_x);
  assign ay_w = DEV_W'(in_data.axis_y);
  assign az_w = DEV_W'(in_data.axis_z);
  assign len2 = ax_w * ax_w + ay_w * ay_w + az_w * az_w;
  assign dev     = len2 - ONE_Q28;
  assign dev_abs = dev[DEV_W-1] ? -dev : dev;

  logic signed [CORD_W-1:0] c_half, s_half;
  avr_cordic u_cordic (
    .clk      (clk),
    .angle    (in_data.angle),
    .cos_half (c_half),
    .sin_half (s_half)
  );

  // align payload with the CORDIC output
  logic signed [VEC_WIDTH-1:0]  vx_d_r [CL+1], vy_d_r [CL+1], vz_d_r [CL+1];
  logic signed [AXIS_WIDTH-1:0] ax_d_r [CL], ay_d_r [CL], az_d_r [CL];
  logic signed [DEV_W-1:0]      dev_d_r [CL+7];

  always_ff @(posedge clk) begin
    vx_d_r[0]  <= in_data.vec_x;
    vy_d_r[0]  <= in_data.vec_y;
    vz_d_r[0]  <= in_data.vec_z;
    ax_d_r[0]  <= in_data.axis_x;
    ay_d_r[0]  <= in_data.axis_y;
    az_d_r[0]  <= in_data.axis_z;
    dev_d_r[0] <= dev_abs;
    for (int k = 1; k < CL + 1; k++) begin
      vx_d_r[k] <= vx_d_r[k-1];
      vy_d_r[k] <= vy_d_r[k-1];
      vz_d_r[k] <= vz_d_r[k-1];
    end
    for (int k = 1; k < CL; k++) begin
      ax_d_r[k] <= ax_d_r[k-1];
      ay_d_r[k] <= ay_d_r[k-1];
      az_d_r[k] <= az_d_r[k-1];
    end
    for (int k = 1; k < CL + 7; k++) dev_d_r[k] <= dev_d_r[k-1];
  end

  // quaternion parts
  logic signed [CORD_W+AXIS_WIDTH-1:0] pi_m, pj_m, pk_m;
  logic signed [Q_W-1:0] qr_r, qi_r, qj_r, qk_r;
  logic signed [Q_W-1:0] qr_d_r [3], qi_d_r [3], qj_d_r [3], qk_d_r [3];

  assign pi_m = s_half * ax_d_r[CL-1];
  assign pj_m = s_half * ay_d_r[CL-1];
  assign pk_m = s_half * az_d_r[CL-1];

  always_ff @(posedge clk) begin
    qr_r <= c_half;
    qi_r <= pi_m[Q_W+13:14];
    qj_r <= pj_m[Q_W+13:14];
    qk_r <= pk_m[Q_W+13:14];
    qr_d_r[0] <= qr_r;
    qi_d_r[0] <= qi_r;
    qj_d_r[0] <= qj_r;
    qk_d_r[0] <= qk_r;
    for (int k = 1; k < 3; k++) begin
      qr_d_r[k] <= qr_d_r[k-1];
      qi_d_r[k] <= qi_d_r[k-1];
      qj_d_r[k] <= qj_d_r[k-1];
      qk_d_r[k] <= qk_d_r[k-1];
    end
  end

  // t = q * (0, v)
  logic signed [Q_W-1:0]       ta [12];
  logic signed [VEC_WIDTH-1:0] tb [12];
  logic signed [TP_W-1:0]      tp [12];
  logic signed [VEC_WIDTH-1:0] vx, vy, vz;

  assign vx = vx_d_r[CL];
  assign vy = vy_d_r[CL];
  assign vz = vz_d_r[CL];

  always_comb begin
    ta[0] = qi_r;  tb[0] = vx;
    ta[1] = qj_r;  tb[1] = vy;
    ta[2] = qk_r;  tb[2] = vz;
    ta[3] = qr_r;  tb[3] = vx;
    ta[4] = qj_r;  tb[4] = vz;
    ta[5] = qk_r;  tb[5] = vy;
    ta[6] = qr_r;  tb[6] = vy;
    ta[7] = qi_r;  tb[7] = vz;
    ta[8] = qk_r;  tb[8] = vx;
    ta[9] = qr_r;  tb[9] = vz;
    ta[10] = qi_r; tb[10] = vy;
    ta[11] = qj_r; tb[11] = vx;
  end

  for (genvar k = 0; k < 12; k++) begin : g_tmul
    avr_qmul #(.B_W(VEC_WIDTH)) u_qmul (.clk(clk), .a(ta[k]), .b(tb[k]), .p(tp[k]));
  end

  logic signed [T_W-1:0] tr_r, ti_r, tj_r, tk_r;
  always_ff @(posedge clk) begin
    tr_r <= -T_W'(tp[0]) - T_W'(tp[1]) - T_W'(tp[2]);
    ti_r <=  T_W'(tp[3]) + T_W'(tp[4]) - T_W'(tp[5]);
    tj_r <=  T_W'(tp[6]) - T_W'(tp[7]) + T_W'(tp[8]);
    tk_r <=  T_W'(tp[9]) + T_W'(tp[10]) - T_W'(tp[11]);
  end

  // u = t * conj(q)
  logic signed [Q_W-1:0]  ua [12];
  logic signed [T_W-1:0]  ub [12];
  logic signed [UP_W-1:0] up [12];
  logic signed [Q_W-1:0]  dr, di, dj, dk;

  assign dr = qr_d_r[2];
  assign di = qi_d_r[2];
  assign dj = qj_d_r[2];
  assign dk = qk_d_r[2];

  always_comb begin
    ua[0] = di;  ub[0] = tr_r;
    ua[1] = dr;  ub[1] = ti_r;
    ua[2] = dk;  ub[2] = tj_r;
    ua[3] = dj;  ub[3] = tk_r;
    ua[4] = dj;  ub[4] = tr_r;
    ua[5] = dk;  ub[5] = ti_r;
    ua[6] = dr;  ub[6] = tj_r;
    ua[7] = di;  ub[7] = tk_r;
    ua[8] = dk;  ub[8] = tr_r;
    ua[9] = dj;  ub[9] = ti_r;
    ua[10] = di; ub[10] = tj_r;
    ua[11] = dr; ub[11] = tk_r;
  end

  for (genvar k = 0; k < 12; k++) begin : g_umul
    avr_qmul #(.B_W(T_W)) u_qmul (.clk(clk), .a(ua[k]), .b(ub[k]), .p(up[k]));
  end

  logic signed [U_W-1:0] ux_r, uy_r, uz_r;
  always_ff @(posedge clk) begin
    ux_r <= -U_W'(up[0]) + U_W'(up[1]) - U_W'(up[2]) + U_W'(up[3]);
    uy_r <= -U_W'(up[4]) + U_W'(up[5]) + U_W'(up[6]) - U_W'(up[7]);
    uz_r <= -U_W'(up[8]) - U_W'(up[9]) + U_W'(up[10]) + U_W'(up[11]);
  end

  // saturate and flag
  localparam logic signed [U_W-1:0] V_MAX = U_W'({1'b0, {(VEC_WIDTH-1){1'b1}}});
  localparam logic signed [U_W-1:0] V_MIN = -V_MAX - U_W'(1);

  logic signed [VEC_WIDTH-1:0] cx, cy, cz;
  logic sx, sy, sz;

  always_comb begin
    sx = (ux_r > V_MAX) || (ux_r < V_MIN);
    sy = (uy_r > V_MAX) || (uy_r < V_MIN);
    sz = (uz_r > V_MAX) || (uz_r < V_MIN);
    cx = (ux_r > V_MAX) ? V_MAX[VEC_WIDTH-1:0] :
         (ux_r < V_MIN) ? V_MIN[VEC_WIDTH-1:0] : ux_r[VEC_WIDTH-1:0];
    cy = (uy_r > V_MAX) ? V_MAX[VEC_WIDTH-1:0] :
         (uy_r < V_MIN) ? V_MIN[VEC_WIDTH-1:0] : uy_r[VEC_WIDTH-1:0];
    cz = (uz_r > V_MAX) ? V_MAX[VEC_WIDTH-1:0] :
         (uz_r < V_MIN) ? V_MIN[VEC_WIDTH-1:0] : uz_r[VEC_WIDTH-1:0];
  end

  out_data_t out_r;
  always_ff @(posedge clk) begin
    out_r.rot_x         <= cx;
    out_r.rot_y         <= cy;
    out_r.rot_z         <= cz;
    out_r.saturated     <= sx || sy || sz;
    out_r.axis_not_unit <= dev_d_r[CL+6] >= $signed({7'd0, tol_r, 14'd0});
  end

  assign out_data  = out_r;
  assign out_valid = vld_r[LAT-1];

  localparam logic signed [VEC_WIDTH-1:0] O_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] O_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  a_result_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without a matching start");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.rot_x == O_MAX) || (out_data.rot_x == O_MIN) ||
      (out_data.rot_y == O_MAX) || (out_data.rot_y == O_MIN) ||
      (out_data.rot_z == O_MAX) || (out_data.rot_z == O_MIN))
    else $error("saturated flag with no clipped component");

  a_zero_tol_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (tol_r == '0) |-> out_data.axis_not_unit)
    else $error("zero tolerance must flag every axis");

endmodule
